// ===== hw/rtl/bst_pkg.sv =====
package bst_pkg;

    localparam int REQ_W     = 3;
    localparam int INDEX_W   = 10;
    localparam int DATA_W    = 32;
    localparam int STATUS_W  = 3;
    localparam int WORD_BITS = 64;
    localparam int BIT_AW    = 6;
    localparam int TDATA_W   = 48;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD    = 3'd0,
        REQ_REMOVE = 3'd1,
        REQ_SET    = 3'd2,
        REQ_GET    = 3'd3,
        REQ_CLEAR  = 3'd4
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_RANGE  = 3'd2,
        ST_UNUSED = 3'd3,
        ST_ZERO   = 3'd4
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_req;
        logic    bm_rd;
        logic    bm_wr;
        logic    val_wr;
        logic    val_rd;
        logic    clear_all;
        logic    set_status;
        status_t status;
        logic    set_alloc;
        logic    set_read;
        logic    out_load;
    } cmd_t;

    // Conditions reported by the datapath.
    typedef struct packed {
        req_t req;
        logic is_zero;
        logic out_range;
        logic none_free;
        logic bit_used;
        logic alloc_over;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hw/rtl/bst_ram.sv =====
module bst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/bst_ctrl.sv =====
module bst_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  bst_pkg::dp_status_t dp_sts,
    output bst_pkg::cmd_t       cmd
);

    import bst_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_EXEC,
        S_GET_WAIT,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = ST_OK;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_DONE;
                case (dp_sts.req)
                    REQ_ADD: begin
                        if (dp_sts.none_free) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_FULL;
                        end else begin
                            cmd.bm_rd  = 1'b1;
                            state_next = S_EXEC;
                        end
                    end
                    REQ_REMOVE, REQ_GET: begin
                        if (dp_sts.out_range) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_RANGE;
                        end else begin
                            cmd.bm_rd  = 1'b1;
                            state_next = S_EXEC;
                        end
                    end
                    REQ_SET: begin
                        // The zero-value check takes priority over the index checks.
                        if (dp_sts.is_zero) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_ZERO;
                        end else if (dp_sts.out_range) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_RANGE;
                        end else begin
                            cmd.bm_rd  = 1'b1;
                            state_next = S_EXEC;
                        end
                    end
                    REQ_CLEAR: begin
                        cmd.clear_all = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_EXEC: begin
                state_next = S_DONE;
                case (dp_sts.req)
                    REQ_ADD: begin
                        if (dp_sts.alloc_over) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_FULL;
                        end else begin
                            cmd.bm_wr     = 1'b1;
                            cmd.val_wr    = 1'b1;
                            cmd.set_alloc = 1'b1;
                        end
                    end
                    REQ_REMOVE: begin
                        if (!dp_sts.bit_used) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_UNUSED;
                        end else begin
                            cmd.bm_wr = 1'b1;
                        end
                    end
                    REQ_SET: begin
                        if (!dp_sts.bit_used) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_UNUSED;
                        end else begin
                            cmd.val_wr = 1'b1;
                        end
                    end
                    REQ_GET: begin
                        if (!dp_sts.bit_used) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_UNUSED;
                        end else begin
                            cmd.val_rd = 1'b1;
                            state_next = S_GET_WAIT;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_GET_WAIT: begin
                cmd.set_read = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE: begin
                if (dp_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/bst_dpath.sv =====
module bst_dpath #(
    parameter int SLOTS       = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [bst_pkg::REQ_W-1:0]     s_req,
    input  logic [bst_pkg::INDEX_W-1:0]   s_slot_index,
    input  logic [bst_pkg::DATA_W-1:0]    s_value,
    input  bst_pkg::cmd_t                 cmd,
    output bst_pkg::dp_status_t           dp_sts,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [bst_pkg::STATUS_W-1:0]  m_status,
    output logic [bst_pkg::INDEX_W-1:0]   m_alloc_index,
    output logic [bst_pkg::DATA_W-1:0]    m_read_value
);

    import bst_pkg::*;

    localparam int WORDS   = (SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SLOT_AW = $clog2(SLOTS);

    // Request registers.
    req_t                   req_reg;
    logic [INDEX_W-1:0]     idx_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [WORD_AW-1:0]     word_addr_reg;

    // Per-word summary: a word whose valid bit is low reads as all free.
    logic [WORDS-1:0]       valid_reg;
    logic [WORDS-1:0]       full_reg;

    // Result being built and the output register.
    status_t                res_status_reg;
    logic [INDEX_W-1:0]     res_alloc_reg;
    logic [DATA_W-1:0]      res_read_reg;
    logic                   out_valid_reg;
    logic [STATUS_W-1:0]    out_status_reg;
    logic [INDEX_W-1:0]     out_alloc_reg;
    logic [DATA_W-1:0]      out_read_reg;

    logic [63:0]            in_value_ext;
    logic [31:0]            idx_slot;
    logic [WORD_AW-1:0]     idx_word;
    logic [WORD_AW-1:0]     free_word;
    logic [WORD_AW-1:0]     bm_raddr;
    logic [WORD_BITS-1:0]   bm_rdata;
    logic [WORD_BITS-1:0]   word_data;
    logic [WORD_BITS-1:0]   new_word;
    logic [BIT_AW-1:0]      free_bit;
    logic [31:0]            alloc_slot;
    logic [SLOT_AW-1:0]     val_addr;
    logic [VALUE_WIDTH-1:0] val_rdata;
    logic [63:0]            val_rdata_ext;

    assign in_value_ext  = 64'(s_value);
    assign idx_slot      = 32'(idx_reg);
    assign idx_word      = idx_slot[BIT_AW +: WORD_AW];
    assign val_rdata_ext = 64'(val_rdata);

    // Lowest word that still has a free bit.
    always_comb begin
        free_word = '0;
        for (int i = WORDS - 1; i >= 0; i--) begin
            if (!full_reg[i]) begin
                free_word = WORD_AW'(i);
            end
        end
    end

    assign bm_raddr  = (req_reg == REQ_ADD) ? free_word : idx_word;
    assign word_data = valid_reg[word_addr_reg] ? bm_rdata : '0;

    // Lowest free bit of the word just read.
    always_comb begin
        free_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!word_data[i]) begin
                free_bit = BIT_AW'(i);
            end
        end
    end

    assign alloc_slot = 32'({word_addr_reg, free_bit});

    always_comb begin
        if (req_reg == REQ_ADD) begin
            new_word = word_data | (WORD_BITS'(1) << free_bit);
        end else begin
            new_word = word_data & ~(WORD_BITS'(1) << idx_reg[BIT_AW-1:0]);
        end
    end

    assign val_addr = (req_reg == REQ_ADD) ? alloc_slot[SLOT_AW-1:0] : idx_slot[SLOT_AW-1:0];

    assign dp_sts.req        = req_reg;
    assign dp_sts.is_zero    = (val_reg == '0);
    assign dp_sts.out_range  = (idx_slot >= 32'(SLOTS));
    assign dp_sts.none_free  = &full_reg;
    assign dp_sts.bit_used   = word_data[idx_reg[BIT_AW-1:0]];
    assign dp_sts.alloc_over = (alloc_slot >= 32'(SLOTS));
    assign dp_sts.out_free   = !out_valid_reg || m_tready;

    bst_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS)
    ) u_bitmap_ram (
        .aclk  (aclk),
        .we    (cmd.bm_wr),
        .waddr (word_addr_reg),
        .wdata (new_word),
        .re    (cmd.bm_rd),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    bst_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (SLOTS)
    ) u_value_ram (
        .aclk  (aclk),
        .we    (cmd.val_wr),
        .waddr (val_addr),
        .wdata (val_reg),
        .re    (cmd.val_rd),
        .raddr (val_addr),
        .rdata (val_rdata)
    );

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg        <= req_t'(s_req);
            idx_reg        <= s_slot_index;
            val_reg        <= in_value_ext[VALUE_WIDTH-1:0];
            res_status_reg <= ST_OK;
            res_alloc_reg  <= '0;
            res_read_reg   <= '0;
        end
        if (cmd.bm_rd) begin
            word_addr_reg <= bm_raddr;
        end
        if (cmd.set_status) begin
            res_status_reg <= cmd.status;
        end
        if (cmd.set_alloc) begin
            res_alloc_reg <= alloc_slot[INDEX_W-1:0];
        end
        if (cmd.set_read) begin
            res_read_reg <= val_rdata_ext[DATA_W-1:0];
        end
        if (cmd.out_load) begin
            out_status_reg <= res_status_reg;
            out_alloc_reg  <= res_alloc_reg;
            out_read_reg   <= res_read_reg;
        end
    end

    // Control state: word summary and output beat valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            full_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.clear_all) begin
                valid_reg <= '0;
                full_reg  <= '0;
            end else if (cmd.bm_wr) begin
                valid_reg[word_addr_reg] <= 1'b1;
                full_reg[word_addr_reg]  <= &new_word;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid      = out_valid_reg;
    assign m_status      = out_status_reg;
    assign m_alloc_index = out_alloc_reg;
    assign m_read_value  = out_read_reg;

endmodule

// ===== hw/rtl/bitmap_slot_table.sv =====
// Steps: clear, unknown and early-rejected requests go from decode straight to done; add,
// remove and set also pass an execute step, and get adds a wait step for its value read
// (one bitmap read, one value read). One request at a time; the next input beat is taken
// once the current result sits in the output register.
// Reset (aresetn, synchronous, active low) frees every slot at once through per-word
// valid bits; slot values are undefined until written.
module bitmap_slot_table #(
    parameter int SLOTS       = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [bst_pkg::TDATA_W-1:0]  s_tdata,  // slot_index[9:0], value[41:10], zero pad
    input  logic [bst_pkg::REQ_W-1:0]    s_tuser,  // req_type[2:0]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [bst_pkg::TDATA_W-1:0]  m_tdata,  // alloc_index[9:0], read_value[41:10], zero pad
    output logic [bst_pkg::STATUS_W-1:0] m_tuser   // status[2:0]
);

    import bst_pkg::*;

    cmd_t               cmd;
    dp_status_t         dp_sts;
    logic [INDEX_W-1:0] alloc_index;
    logic [DATA_W-1:0]  read_value;

    bst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .dp_sts   (dp_sts),
        .cmd      (cmd)
    );

    bst_dpath #(
        .SLOTS       (SLOTS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_req         (s_tuser),
        .s_slot_index  (s_tdata[INDEX_W-1:0]),
        .s_value       (s_tdata[INDEX_W +: DATA_W]),
        .cmd           (cmd),
        .dp_sts        (dp_sts),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .m_status      (m_tuser),
        .m_alloc_index (alloc_index),
        .m_read_value  (read_value)
    );

    assign m_tdata = TDATA_W'({read_value, alloc_index});

endmodule

// ===== test/bitmap_slot_table_tb.sv =====
`timescale 1ns / 1ps

module bitmap_slot_table_tb;
    import bst_pkg::*;

    localparam int NUM_SLOTS     = 1024;
    localparam int NUM_WORDS     = NUM_SLOTS / WORD_BITS;
    localparam int WATCHDOG_IDLE = 3000;
    localparam int HOLD_CYCLES   = 300;
    localparam int MIXED_ITEMS   = 100;
    localparam int N_DIRECTED    = 23;

    // Request codes that the block treats as no-ops.
    localparam logic [REQ_W-1:0] REQ_SPARE_5 = 3'd5;
    localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

    typedef struct packed {
        status_t             status;
        logic [INDEX_W-1:0]  alloc_index;
        logic [DATA_W-1:0]   read_value;
    } slot_reply_t;

    typedef struct packed {
        logic [REQ_W-1:0]    req;
        logic [INDEX_W-1:0]  idx;
        logic [DATA_W-1:0]   val;
        logic                typed;
        slot_reply_t         reply;
    } stim_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata;
    logic [REQ_W-1:0]     s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    // Shadow of the table: used bitmap and stored values.
    logic [WORD_BITS-1:0] used_words [NUM_WORDS];
    logic [DATA_W-1:0]    slot_data [NUM_SLOTS];

    slot_reply_t          predicted_replies [$];
    int                   mismatch_count = 0;
    int                   src_max_gap = 6;
    int                   snk_max_gap = 6;
    bit                   hold_off_request = 0;
    bit                   stim_done = 0;

    // Directed rows: typed replies only where they are obvious.
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{REQ_GET,     10'd0,    32'h0,        1'b1, '{ST_UNUSED, 10'd0, 32'h0}},
        '{REQ_REMOVE,  10'd1023, 32'h0,        1'b1, '{ST_UNUSED, 10'd0, 32'h0}},
        '{REQ_SET,     10'd5,    32'h0,        1'b1, '{ST_ZERO,   10'd0, 32'h0}},
        '{REQ_ADD,     10'd0,    32'h0,        1'b1, '{ST_OK,     10'd0, 32'h0}},
        '{REQ_ADD,     10'd1023, 32'hFFFFFFFF, 1'b1, '{ST_OK,     10'd1, 32'h0}},
        '{REQ_ADD,     10'd512,  32'h12345678, 1'b0, '{ST_OK,     10'd0, 32'h0}},
        '{REQ_GET,     10'd0,    32'hFFFFFFFF, 1'b1, '{ST_OK,     10'd0, 32'h0}},
        '{REQ_GET,     10'd1,    32'h0,        1'b1, '{ST_OK,     10'd0, 32'hFFFFFFFF}},
        '{REQ_SET,     10'd1,    32'h1,        1'b0, '{ST_OK,     10'd0, 32'h0}},
        '{REQ_GET,     10'd1,    32'h0,        1'b1, '{ST_OK,     10'd0, 32'h1}},
        '{REQ_SET,     10'd1,    32'h0,        1'b1, '{ST_ZERO,   10'd0, 32'h0}},
        '{REQ_SET,     10'd900,  32'h5,        1'b1, '{ST_UNUSED, 10'd0, 32'h0}},
        '{REQ_REMOVE,  10'd0,    32'h0,        1'b0, '{ST_OK,     10'd0, 32'h0}},
        '{REQ_GET,     10'd0,    32'h0,        1'b1, '{ST_UNUSED, 10'd0, 32'h0}},
        '{REQ_ADD,     10'd3,    32'hA5A5A5A5, 1'b1, '{ST_OK,     10'd0, 32'h0}},
        '{REQ_SPARE_5, 10'd1023, 32'hFFFFFFFF, 1'b1, '{ST_OK,     10'd0, 32'h0}},
        '{REQ_SPARE_6, 10'd2,    32'h5A5A5A5A, 1'b1, '{ST_OK,     10'd0, 32'h0}},
        '{REQ_SPARE_7, 10'd0,    32'h0,        1'b1, '{ST_OK,     10'd0, 32'h0}},
        '{REQ_CLEAR,   10'd0,    32'h0,        1'b1, '{ST_OK,     10'd0, 32'h0}},
        '{REQ_GET,     10'd1,    32'h0,        1'b1, '{ST_UNUSED, 10'd0, 32'h0}},
        '{REQ_ADD,     10'd0,    32'h55,       1'b1, '{ST_OK,     10'd0, 32'h0}},
        '{REQ_GET,     10'd0,    32'h0,        1'b0, '{ST_OK,     10'd0, 32'h0}},
        '{REQ_REMOVE,  10'd1023, 32'hFFFFFFFF, 1'b1, '{ST_UNUSED, 10'd0, 32'h0}}
    };

    bitmap_slot_table DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic bit slot_busy(input int slot);
        return used_words[slot / WORD_BITS][slot % WORD_BITS];
    endfunction

    function automatic int slots_in_use();
        int n;
        n = 0;
        for (int w = 0; w < NUM_WORDS; w++) begin
            n += $countones(used_words[w]);
        end
        return n;
    endfunction

    // Applies one request to the shadow table and returns the reply it yields.
    function automatic slot_reply_t predict_reply(input logic [REQ_W-1:0] req,
                                                  input logic [INDEX_W-1:0] idx,
                                                  input logic [DATA_W-1:0] val);
        slot_reply_t r;
        int          slot;
        bit          found;
        r.status      = ST_OK;
        r.alloc_index = '0;
        r.read_value  = '0;
        found = 1'b0;
        slot  = 0;
        case (req)
            REQ_ADD: begin
                for (int s = 0; s < NUM_SLOTS; s++) begin
                    if (!found && !slot_busy(s)) begin
                        found = 1'b1;
                        slot  = s;
                    end
                end
                if (found) begin
                    slot_data[slot] = val;
                    used_words[slot / WORD_BITS][slot % WORD_BITS] = 1'b1;
                    r.alloc_index = slot[INDEX_W-1:0];
                end else begin
                    r.status = ST_FULL;
                end
            end
            REQ_REMOVE: begin
                if (int'(idx) >= NUM_SLOTS) r.status = ST_RANGE;
                else if (!slot_busy(int'(idx))) r.status = ST_UNUSED;
                else used_words[idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
            end
            REQ_SET: begin
                // The zero check wins over the range and use checks.
                if (val == '0) r.status = ST_ZERO;
                else if (int'(idx) >= NUM_SLOTS) r.status = ST_RANGE;
                else if (!slot_busy(int'(idx))) r.status = ST_UNUSED;
                else slot_data[idx] = val;
            end
            REQ_GET: begin
                if (int'(idx) >= NUM_SLOTS) r.status = ST_RANGE;
                else if (!slot_busy(int'(idx))) r.status = ST_UNUSED;
                else r.read_value = slot_data[idx];
            end
            REQ_CLEAR: begin
                for (int w = 0; w < NUM_WORDS; w++) used_words[w] = '0;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [TDATA_W-1:0] got,
                                   input logic [TDATA_W-1:0] want);
        mismatch_count++;
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    // Offers one request beat and records the reply it must produce.
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [INDEX_W-1:0] idx,
                                input logic [DATA_W-1:0] val, input bit typed,
                                input slot_reply_t typed_reply);
        int          gap;
        slot_reply_t r;
        gap = $urandom_range(0, src_max_gap);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {{(TDATA_W - INDEX_W - DATA_W){1'b0}}, val, idx};
        do @(posedge aclk); while (!s_tready);
        r = predict_reply(req, idx, val);
        predicted_replies.push_back(typed ? typed_reply : r);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) return '0;
        if (roll < 15) return '1;
        return $urandom;
    endfunction

    // Most indices land in the dense low region where first fit places entries.
    function automatic logic [INDEX_W-1:0] pick_index();
        int hi;
        if ($urandom_range(0, 99) < 15) return INDEX_W'($urandom_range(0, NUM_SLOTS - 1));
        hi = slots_in_use() + 4;
        if (hi > NUM_SLOTS - 1) hi = NUM_SLOTS - 1;
        return INDEX_W'($urandom_range(0, hi));
    endfunction

    task automatic send_mixed();
        int               roll;
        logic [REQ_W-1:0] req;
        roll = $urandom_range(0, 99);
        if (roll < 35) req = REQ_ADD;
        else if (roll < 55) req = REQ_REMOVE;
        else if (roll < 72) req = REQ_SET;
        else if (roll < 94) req = REQ_GET;
        else if (roll < 96) req = REQ_CLEAR;
        else req = REQ_W'($urandom_range(5, 7));
        send_request(req, pick_index(), pick_value(), 1'b0, '0);
    endtask

    task automatic pick_idle_stretch();
        src_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 6;
        snk_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 6;
    endtask

    task automatic drain_replies();
        while (predicted_replies.size() != 0) @(posedge aclk);
    endtask

    // Stimulus and end of run.
    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        for (int w = 0; w < NUM_WORDS; w++) used_words[w] = '0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_request(directed_rows[i].req, directed_rows[i].idx, directed_rows[i].val,
                         directed_rows[i].typed, directed_rows[i].reply);
        end

        for (int i = 0; i < MIXED_ITEMS; i++) begin
            if (i % 40 == 0) pick_idle_stretch();
            send_mixed();
        end

        // The receiver stalls for a long stretch while beats keep coming.
        src_max_gap = 0;
        hold_off_request = 1'b1;
        for (int i = 0; i < 20; i++) send_mixed();

        // The sender waits until every reply is back.
        @(negedge aclk);
        s_tvalid <= 1'b0;
        drain_replies();

        // Fill the table to the last slot, then push past it.
        src_max_gap = 1;
        snk_max_gap = 2;
        while (slots_in_use() < NUM_SLOTS) begin
            send_request(REQ_ADD, INDEX_W'($urandom), $urandom, 1'b0, '0);
        end
        src_max_gap = 6;
        snk_max_gap = 6;
        for (int i = 0; i < 3; i++) begin
            send_request(REQ_ADD, INDEX_W'($urandom), $urandom, 1'b0, '0);
        end
        send_request(REQ_GET, 10'd1023, 32'h0, 1'b0, '0);
        send_request(REQ_SET, 10'd1023, 32'hDEADBEEF, 1'b0, '0);
        send_request(REQ_GET, 10'd1023, 32'h0, 1'b0, '0);
        send_request(REQ_REMOVE, 10'd1023, 32'h0, 1'b0, '0);
        for (int i = 0; i < 3; i++) begin
            send_request(REQ_REMOVE, INDEX_W'($urandom_range(0, NUM_SLOTS - 1)), 32'h0,
                         1'b0, '0);
        end
        for (int i = 0; i < 6; i++) begin
            send_request(REQ_ADD, INDEX_W'($urandom), $urandom, 1'b0, '0);
        end
        for (int i = 0; i < 10; i++) send_mixed();
        send_request(REQ_CLEAR, INDEX_W'($urandom), $urandom, 1'b0, '0);

        for (int i = 0; i < MIXED_ITEMS; i++) begin
            if (i % 40 == 0) pick_idle_stretch();
            send_mixed();
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        drain_replies();
        repeat (10) @(posedge aclk);
        stim_done = 1'b1;
        if (predicted_replies.size() != 0) begin
            report_mismatch("replies left over", TDATA_W'(predicted_replies.size()),
                            TDATA_W'(0));
        end
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Result side back-pressure.
    initial begin
        int gap;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            gap = $urandom_range(0, snk_max_gap);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Compare every reply beat with the oldest prediction.
    always @(posedge aclk) begin
        slot_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (predicted_replies.size() == 0) begin
                report_mismatch("beat with no request pending", m_tdata, TDATA_W'(0));
            end else begin
                want = predicted_replies.pop_front();
                if (m_tuser !== want.status) begin
                    report_mismatch("status", TDATA_W'(m_tuser), TDATA_W'(want.status));
                end
                if (m_tdata[INDEX_W-1:0] !== want.alloc_index) begin
                    report_mismatch("alloc_index", TDATA_W'(m_tdata[INDEX_W-1:0]),
                                    TDATA_W'(want.alloc_index));
                end
                if (m_tdata[INDEX_W +: DATA_W] !== want.read_value) begin
                    report_mismatch("read_value", TDATA_W'(m_tdata[INDEX_W +: DATA_W]),
                                    TDATA_W'(want.read_value));
                end
                if (m_tdata[TDATA_W-1:INDEX_W+DATA_W] !== '0) begin
                    report_mismatch("tdata padding", m_tdata, TDATA_W'(0));
                end
            end
        end
    end

    // Ends the run if neither channel moves a beat for too long.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_IDLE) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || stim_done) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("FAILED: results differ");
        $finish;
    end

endmodule
